[design/tcc_pkg.sv]
// Shared constants, types and command codes for the text console engine.
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

   // Screen geometry
   localparam int COLUMNS       = 80;
   localparam int ROWS          = 25;
   localparam int CELL_COUNT    = ROWS * COLUMNS;
   localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

   // Derived widths
   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int CNT_W  = $clog2(CELL_COUNT + 1);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);

   // Field widths of the stream channels
   localparam int REQ_TYPE_W  = 2;
   localparam int CHAR_W      = 8;
   localparam int REQ_ADDR_W  = 11;
   localparam int OFFSET_W    = 11;
   localparam int CELL_W      = 16;
   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_TUSER_W = 1;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int COLOR_W     = 4;
   localparam int ATTR_W      = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_FG_COLOR    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BG_COLOR    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLANK_ATTR  = 2'd2;

   localparam logic [COLOR_W-1:0] FG_COLOR_RESET   = 4'hF;
   localparam logic [COLOR_W-1:0] BG_COLOR_RESET   = 4'h0;
   localparam logic [ATTR_W-1:0]  BLANK_ATTR_RESET = 8'h0F;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_PUT   = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd2;

   // Special characters
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

   // Command queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      CMD_CHAR,
      CMD_NEWLINE,
      CMD_BACKSPACE,
      CMD_CLEAR,
      CMD_READ,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [CHAR_W-1:0]   char_code;
      logic [ADDR_W-1:0]   addr;
      logic                addr_valid;
   } cmd_type;

   typedef struct packed {
      logic [COLOR_W-1:0] fg_color;
      logic [COLOR_W-1:0] bg_color;
      logic [ATTR_W-1:0]  blank_attr;
   } cfg_type;

   typedef struct packed {
      logic init_done;
   } back_status_type;

endpackage

`default_nettype wire

[design/tcc_front.sv]
// Request front end: accepts transactions and decodes them into queue commands.
`timescale 1ns / 1ps
`default_nettype none

module tcc_front (
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [tcc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  wire logic [tcc_pkg::REQ_TUSER_W-1:0]   req_tuser,
   input  wire tcc_pkg::back_status_type          back_status,
   input  wire logic                              queue_full,
   output logic                                   push,
   output tcc_pkg::cmd_type                       cmd
);
   import tcc_pkg::*;

   logic [CHAR_W-1:0]     char_code;
   logic [REQ_ADDR_W-1:0] cell_address;

   assign char_code    = req_tdata[CHAR_W-1:0];
   assign cell_address = req_tdata[CHAR_W +: REQ_ADDR_W];

   // Hold off requests during the power-up blanking pass and when the queue is full
   assign req_tready = back_status.init_done && !queue_full;
   assign push       = req_tvalid && req_tready;

   // Classify the request
   always_comb begin
      cmd.char_code  = char_code;
      cmd.addr       = ADDR_W'(cell_address);
      cmd.addr_valid = (32'(cell_address) < 32'(CELL_COUNT));
      unique case (req_tuser)
         REQ_PUT: begin
            if (char_code == CH_NEWLINE) begin
               cmd.kind = CMD_NEWLINE;
            end else if (char_code == CH_BACKSPACE) begin
               cmd.kind = CMD_BACKSPACE;
            end else begin
               cmd.kind = CMD_CHAR;
            end
         end
         REQ_CLEAR: begin
            cmd.kind = CMD_CLEAR;
         end
         REQ_READ: begin
            cmd.kind = CMD_READ;
         end
         default: begin
            cmd.kind = CMD_NOP;
         end
      endcase
   end

endmodule

`default_nettype wire

[design/tcc_cmd_queue.sv]
// Short command queue between the request front end and the screen back end.
`timescale 1ns / 1ps
`default_nettype none

module tcc_cmd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire tcc_pkg::cmd_type cmd_in,
   input  wire logic             pop,
   output tcc_pkg::cmd_type      head,
   output logic                  empty,
   output logic                  full
);
   import tcc_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

`default_nettype wire

[design/tcc_back.sv]
// Screen back end: screen store, cursor, scroll and clear sequencer, result register.
`timescale 1ns / 1ps
`default_nettype none

module tcc_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tcc_pkg::cfg_type                  cfg,
   input  wire tcc_pkg::cmd_type                  head,
   input  wire logic                              queue_empty,
   output logic                                   pop,
   output tcc_pkg::back_status_type               back_status,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [tcc_pkg::OFFSET_W-1:0]           rsp_offset,
   output logic [tcc_pkg::CELL_W-1:0]             rsp_cell,
   output logic                                   rsp_scrolled
);
   import tcc_pkg::*;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_FILL,
      ST_CLEAR,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [ADDR_W-1:0]    lin_ff, lin_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 scrolled_ff, scrolled_in;
   logic                 read_ok_ff, read_ok_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_W-1:0]  rsp_offset_ff, rsp_offset_in;
   logic [CELL_W-1:0]    rsp_cell_ff, rsp_cell_in;
   logic                 rsp_scrolled_ff, rsp_scrolled_in;

   // Screen store
   logic [CELL_W-1:0]    screen_mem [CELL_COUNT];
   logic [CELL_W-1:0]    rd_data_ff;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [ADDR_W-1:0]    mem_raddr;
   logic [CELL_W-1:0]    mem_wdata;

   logic                 out_free;
   logic                 load_now;
   logic [CELL_W-1:0]    load_cell;
   logic                 load_scrolled;
   logic                 at_last_col;
   logic                 at_last_row;
   logic [ADDR_W-1:0]    lin_back;
   logic [CELL_W-1:0]    blank_cell;
   logic [CELL_W-1:0]    char_cell;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign at_last_col = (col_ff == COL_W'(COLUMNS - 1));
   assign at_last_row = (row_ff == ROW_W'(ROWS - 1));
   assign lin_back    = (lin_ff == '0) ? '0 : lin_ff - 1'b1;
   assign blank_cell  = {cfg.blank_attr, CH_SPACE};
   assign char_cell   = {cfg.bg_color, cfg.fg_color, head.char_code};

   // Next-state logic
   always_comb begin
      state_in        = state_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      lin_in          = lin_ff;
      cnt_in          = cnt_ff;
      scrolled_in     = scrolled_ff;
      read_ok_in      = read_ok_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_offset_in   = rsp_offset_ff;
      rsp_cell_in     = rsp_cell_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      mem_we          = 1'b0;
      mem_waddr       = '0;
      mem_wdata       = '0;
      mem_raddr       = head.addr;
      pop             = 1'b0;
      load_now        = 1'b0;
      load_cell       = '0;
      load_scrolled   = 1'b0;

      unique case (state_ff)
         // Blank the store after reset with the reset attribute
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[ADDR_W-1:0];
            mem_wdata = {BLANK_ATTR_RESET, CH_SPACE};
            if (cnt_ff == CNT_W'(CELL_COUNT - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (!queue_empty && out_free) begin
               pop = 1'b1;
               unique case (head.kind)
                  CMD_CHAR: begin
                     mem_we    = 1'b1;
                     mem_waddr = lin_ff;
                     mem_wdata = char_cell;
                     if (at_last_col) begin
                        col_in = '0;
                        if (at_last_row) begin
                           lin_in      = ADDR_W'(LAST_ROW_BASE);
                           cnt_in      = CNT_W'(COLUMNS);
                           scrolled_in = 1'b1;
                           state_in    = ST_COPY;
                        end else begin
                           row_in   = row_ff + 1'b1;
                           lin_in   = lin_ff + 1'b1;
                           load_now = 1'b1;
                        end
                     end else begin
                        col_in   = col_ff + 1'b1;
                        lin_in   = lin_ff + 1'b1;
                        load_now = 1'b1;
                     end
                  end
                  CMD_NEWLINE: begin
                     col_in = '0;
                     if (at_last_row) begin
                        lin_in      = ADDR_W'(LAST_ROW_BASE);
                        cnt_in      = CNT_W'(COLUMNS);
                        scrolled_in = 1'b1;
                        state_in    = ST_COPY;
                     end else begin
                        row_in   = row_ff + 1'b1;
                        lin_in   = lin_ff + ADDR_W'(COLUMNS) - ADDR_W'(col_ff);
                        load_now = 1'b1;
                     end
                  end
                  CMD_BACKSPACE: begin
                     // Step back across the row start; stay put at the origin
                     if (col_ff != '0) begin
                        col_in = col_ff - 1'b1;
                     end else if (row_ff != '0) begin
                        row_in = row_ff - 1'b1;
                        col_in = COL_W'(COLUMNS - 1);
                     end
                     lin_in    = lin_back;
                     mem_we    = 1'b1;
                     mem_waddr = lin_back;
                     mem_wdata = blank_cell;
                     load_now  = 1'b1;
                  end
                  CMD_CLEAR: begin
                     col_in      = '0;
                     row_in      = '0;
                     lin_in      = '0;
                     cnt_in      = '0;
                     scrolled_in = 1'b0;
                     state_in    = ST_CLEAR;
                  end
                  CMD_READ: begin
                     read_ok_in = head.addr_valid;
                     state_in   = ST_READ;
                  end
                  default: begin
                     load_now = 1'b1;
                  end
               endcase
            end
         end

         // Read data is registered; the result slot was freed on entry
         ST_READ: begin
            load_now  = 1'b1;
            load_cell = read_ok_ff ? rd_data_ff : '0;
            state_in  = ST_IDLE;
         end

         // Move every row up one: read one row ahead, write the previous read
         ST_COPY: begin
            if (cnt_ff < CNT_W'(CELL_COUNT)) begin
               mem_raddr = cnt_ff[ADDR_W-1:0];
            end
            if (cnt_ff != CNT_W'(COLUMNS)) begin
               mem_we    = 1'b1;
               mem_waddr = ADDR_W'(cnt_ff - CNT_W'(COLUMNS + 1));
               mem_wdata = rd_data_ff;
            end
            if (cnt_ff == CNT_W'(CELL_COUNT)) begin
               cnt_in   = CNT_W'(LAST_ROW_BASE);
               state_in = ST_FILL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // Blank the bottom row after a scroll
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[ADDR_W-1:0];
            mem_wdata = blank_cell;
            if (cnt_ff == CNT_W'(CELL_COUNT - 1)) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // Blank the whole screen
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[ADDR_W-1:0];
            mem_wdata = blank_cell;
            if (cnt_ff == CNT_W'(CELL_COUNT - 1)) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               load_now      = 1'b1;
               load_scrolled = scrolled_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Load the result register
      if (load_now) begin
         rsp_valid_in    = 1'b1;
         rsp_offset_in   = OFFSET_W'(lin_in);
         rsp_cell_in     = load_cell;
         rsp_scrolled_in = load_scrolled;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         col_ff       <= '0;
         row_ff       <= '0;
         lin_ff       <= '0;
         cnt_ff       <= '0;
         scrolled_ff  <= 1'b0;
         read_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         lin_ff       <= lin_in;
         cnt_ff       <= cnt_in;
         scrolled_ff  <= scrolled_in;
         read_ok_ff   <= read_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_offset_ff   <= rsp_offset_in;
      rsp_cell_ff     <= rsp_cell_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   // Screen store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= screen_mem[mem_raddr];
   end

   assign back_status.init_done = (state_ff != ST_INIT);
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_offset   = rsp_offset_ff;
   assign rsp_cell     = rsp_cell_ff;
   assign rsp_scrolled = rsp_scrolled_ff;

endmodule

`default_nettype wire

[design/text_console_cursor_scroll.sv]
// Top level of the character-cell text console engine.
`timescale 1ns / 1ps
`default_nettype none

// Text console engine keeping a ROWS x COLUMNS screen of 16-bit cells (attribute in the
// high byte, character in the low byte) and a cursor. Each request transaction yields
// exactly one result transaction carrying the linear cursor offset. After reset the
// screen store is blanked in a pass over all CELL_COUNT cells (2000 at 80 x 25), during
// which req_tready stays low; configuration writes are taken throughout. Printable
// characters, newline, backspace and unused request codes complete at one per cycle
// while results are taken and no scroll is needed. A cell read passes through the
// registered read port of the screen store. A put that scrolls runs a copy pass moving
// each row up through the read and write ports, then blanks the bottom row; a clear
// blanks the whole screen at one cell write per cycle. A two-entry command queue lets
// requests be taken while the back end is busy.
module text_console_cursor_scroll (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [tcc_pkg::REQ_TDATA_W-1:0]   req_tdata,  // char_code, cell_address
   input  wire logic [tcc_pkg::REQ_TUSER_W-1:0]   req_tuser,  // req_type
   // Result stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [tcc_pkg::RSP_TDATA_W-1:0]        rsp_tdata,  // cursor_offset, cell_data
   output logic [tcc_pkg::RSP_TUSER_W-1:0]        rsp_tuser,  // scrolled
   // Configuration write channel
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [tcc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [tcc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tcc_pkg::*;

   cfg_type            cfg_ff, cfg_in;
   back_status_type    back_status;
   cmd_type            front_cmd;
   cmd_type            queue_head;
   logic               front_push;
   logic               queue_empty;
   logic               queue_full;
   logic               back_pop;
   logic [OFFSET_W-1:0] rsp_offset;
   logic [CELL_W-1:0]   rsp_cell;
   logic                rsp_scrolled;

   // Configuration registers; writes beyond the list are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FG_COLOR:   cfg_in.fg_color   = csr_wdata[COLOR_W-1:0];
            CSR_BG_COLOR:   cfg_in.bg_color   = csr_wdata[COLOR_W-1:0];
            CSR_BLANK_ATTR: cfg_in.blank_attr = csr_wdata[ATTR_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fg_color   <= FG_COLOR_RESET;
         cfg_ff.bg_color   <= BG_COLOR_RESET;
         cfg_ff.blank_attr <= BLANK_ATTR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tcc_front u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .back_status (back_status),
      .queue_full  (queue_full),
      .push        (front_push),
      .cmd         (front_cmd)
   );

   tcc_cmd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (front_push),
      .cmd_in (front_cmd),
      .pop    (back_pop),
      .head   (queue_head),
      .empty  (queue_empty),
      .full   (queue_full)
   );

   tcc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .head         (queue_head),
      .queue_empty  (queue_empty),
      .pop          (back_pop),
      .back_status  (back_status),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_offset   (rsp_offset),
      .rsp_cell     (rsp_cell),
      .rsp_scrolled (rsp_scrolled)
   );

   // Pack the result fields
   assign rsp_tdata = {{(RSP_TDATA_W - OFFSET_W - CELL_W){1'b0}}, rsp_cell, rsp_offset};
   assign rsp_tuser = rsp_scrolled;

   // No request is taken before the store has been blanked
   a_init_holds_off: assert property (@(posedge clock) disable iff (reset)
      !back_status.init_done |-> !req_tready)
      else $error("request accepted during the blanking pass");

   // The reported cursor always lies on the screen
   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[OFFSET_W-1:0]) < 32'(CELL_COUNT)))
      else $error("cursor offset beyond the screen");

   // A scroll leaves the cursor at the start of the bottom row
   a_scroll_home: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[OFFSET_W-1:0] == OFFSET_W'(LAST_ROW_BASE)))
      else $error("scroll left the cursor off the bottom row start");

endmodule

`default_nettype wire
